FILE: design/text_console_glyph_renderer_assert.svh
// Assertion macros shared by the checker file.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TCGR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs while reset is applied.
`define TCGR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tcgr_pkg.sv
package tcgr_pkg;

    localparam int GLYPH_WIDTH    = 8;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPH_SLOTS    = 256;

    localparam int FONT_AW   = 13;
    localparam int FONT_DW   = 8;
    localparam int ROW_IDX_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 8;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd2;

    localparam logic [7:0] RST_COLUMNS      = 8'd80;
    localparam logic [7:0] RST_TEXT_ROWS    = 8'd25;
    localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Per-character setup latched when a put item is accepted.
    typedef struct packed {
        logic [10:0]          base_x;
        logic [12:0]          base_y;
        logic [7:0]           code;
        logic [ROW_IDX_W-1:0] h_last;
        logic                 nop;
        logic                 scroll;
    } char_setup_t;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [12:0] pixel_y;
        logic [7:0]  row_pixels;
        logic        row_valid;
        logic        scroll_up;
        logic        last;
    } result_t;

endpackage

FILE: design/text_console_glyph_renderer.sv
// A put item's setup is latched on acceptance; each font row read registers the RAM data
//   and its metadata, that go into the output queue. One font row is read per cycle,
//   while the output queue has room, from the single read port of the font RAM; a new
//   item is taken only with the last row read. A glyph item yields min(glyph_height, 32)
//   results (one if zero). Reset (aresetn low, synchronous): cursor to 0,0, registers to 80/25/16, queue empty.
// The font RAM is not cleared; entries hold garbage until loaded.
module text_console_glyph_renderer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] char_code, [20:8] font_address, [28:21] font_byte, [31:29] zero
    input  logic [31:0]                   s_tdata,
    // [0] operation
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] pixel_x, [23:11] pixel_y, [31:24] row_pixels
    output logic [31:0]                   m_tdata,
    // [0] row_valid, [1] scroll_up
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcgr_pkg::CFG_DW-1:0]   cfg_wdata
);

    import tcgr_pkg::*;

    state_t      state_reg, state_next;
    char_setup_t setup_reg, setup_new;
    logic [ROW_IDX_W-1:0] i_reg;
    logic        inflight_reg;
    result_t     meta_reg, push_data, head;
    logic [FONT_DW-1:0] rdata;
    logic [1:0]  occ;
    logic        s_accept, is_put, is_load, issue, credit_ok, i_last, pop;

    assign s_accept = s_tvalid & s_tready;
    assign is_put   = (s_tuser[0] == OP_PUT);
    assign is_load  = (s_tuser[0] == OP_LOAD);
    assign pop      = m_tvalid & m_tready;
    assign i_last   = (i_reg == setup_reg.h_last);
    // room for one more item once everything queued or in the RAM has landed
    assign credit_ok = ({1'b0, occ} + {2'b00, inflight_reg}) < (3'd2 + {2'b00, pop});

    tcgr_cursor u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .char_en   (s_accept & is_put),
        .char_code (s_tdata[7:0]),
        .setup     (setup_new)
    );

    tcgr_font_ram #(
        .AW (FONT_AW),
        .DW (FONT_DW)
    ) u_font_ram (
        .aclk  (aclk),
        .we    (s_accept & is_load),
        .waddr (s_tdata[20:8]),
        .wdata (s_tdata[28:21]),
        .re    (issue & ~setup_reg.nop),
        .raddr ({setup_reg.code, i_reg}),
        .rdata (rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && is_put) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue && i_last) begin
                    state_next = (s_accept && is_put) ? ST_EMIT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        issue    = 1'b0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EMIT: begin
                issue    = credit_ok;
                s_tready = credit_ok & i_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            inflight_reg <= 1'b0;
            i_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            inflight_reg <= issue;
            if (s_accept && is_put) begin
                i_reg <= '0;
            end else if (issue && !i_last) begin
                i_reg <= i_reg + ROW_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_put) begin
            setup_reg <= setup_new;
        end
        if (issue) begin
            meta_reg.pixel_x    <= setup_reg.nop ? 11'd0 : setup_reg.base_x;
            meta_reg.pixel_y    <= setup_reg.nop ? 13'd0
                                                 : setup_reg.base_y + {8'd0, i_reg};
            meta_reg.row_pixels <= 8'd0;
            meta_reg.row_valid  <= ~setup_reg.nop;
            meta_reg.scroll_up  <= setup_reg.scroll & (i_reg == '0);
            meta_reg.last       <= i_last;
        end
    end

    always_comb begin
        push_data            = meta_reg;
        push_data.row_pixels = meta_reg.row_valid ? rdata : 8'd0;
    end

    tcgr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (inflight_reg),
        .din       (push_data),
        .pop       (pop),
        .dout      (head),
        .not_empty (m_tvalid),
        .count     (occ)
    );

    assign m_tdata = {head.row_pixels, head.pixel_y, head.pixel_x};
    assign m_tuser = {head.scroll_up, head.row_valid};
    assign m_tlast = head.last;

endmodule

FILE: design/tcgr_font_ram.sv
module tcgr_font_ram #(
    parameter int AW = 13,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/tcgr_cursor.sv
module tcgr_cursor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcgr_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                          char_en,
    input  logic [7:0]                    char_code,
    output tcgr_pkg::char_setup_t         setup
);

    import tcgr_pkg::*;

    logic [7:0] columns_reg, text_rows_reg;
    logic [5:0] glyph_height_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;

    logic [7:0]  cols, rows;
    logic [5:0]  h6, h6_m1;
    logic        wrap0, wrap3, is_nl, is_cr, ctrl, scroll;
    logic [7:0]  col0, col1, col2;
    logic [8:0]  row0;
    logic [9:0]  row1;
    logic [7:0]  row2;
    logic [8:0]  col3;
    logic [13:0] prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg      <= RST_COLUMNS;
            text_rows_reg    <= RST_TEXT_ROWS;
            glyph_height_reg <= RST_GLYPH_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COLUMNS:      columns_reg      <= cfg_wdata;
                CFG_TEXT_ROWS:    text_rows_reg    <= cfg_wdata;
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cols  = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
        rows  = (text_rows_reg == 8'd0) ? 8'd1 : text_rows_reg;
        h6    = (glyph_height_reg > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS)
                                                         : glyph_height_reg;
        h6_m1 = (h6 == 6'd0) ? 6'd0 : h6 - 6'd1;

        // column left past the edge by a register change wraps first
        wrap0 = (col_reg >= cols);
        col0  = wrap0 ? 8'd0 : col_reg;
        row0  = {1'b0, row_reg} + {8'd0, wrap0};

        is_nl = (char_code == CODE_NEWLINE);
        is_cr = (char_code == CODE_RETURN);
        ctrl  = is_nl | is_cr;
        row1  = {1'b0, row0} + {9'd0, is_nl};
        col1  = ctrl ? 8'd0 : col0;

        scroll = (row1 >= {2'b00, rows});
        row2   = scroll ? rows - 8'd1 : row1[7:0];
        col2   = scroll ? 8'd0 : col1;

        col3  = {1'b0, col2} + 9'd1;
        wrap3 = (col3 >= {1'b0, cols});

        if (ctrl) begin
            col_next = col2;
            row_next = row2;
        end else if (wrap3) begin
            col_next = 8'd0;
            row_next = row2 + 8'd1;
        end else begin
            col_next = col3[7:0];
            row_next = row2;
        end

        prod = {6'd0, row2} * {8'd0, h6};

        setup.base_x = {col2, 3'b000};
        setup.base_y = prod[12:0];
        setup.code   = char_code;
        // an item without glyph rows yields a single result
        setup.h_last = (ctrl | (h6 == 6'd0)) ? {ROW_IDX_W{1'b0}} : h6_m1[ROW_IDX_W-1:0];
        setup.nop    = ctrl | (h6 == 6'd0);
        setup.scroll = scroll;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end else if (char_en) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: design/tcgr_out_fifo.sv
module tcgr_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tcgr_pkg::result_t din,
    input  logic              pop,
    output tcgr_pkg::result_t dout,
    output logic              not_empty,
    output logic [1:0]        count
);

    import tcgr_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    e0_reg, e1_reg;

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                e0_reg <= din;
            end else begin
                e0_reg <= e1_reg;
                e1_reg <= din;
            end
        end else if (pop) begin
            e0_reg <= e1_reg;
        end else if (push) begin
            if (count_reg == 2'd0) begin
                e0_reg <= din;
            end else begin
                e1_reg <= din;
            end
        end
    end

    assign dout      = e0_reg;
    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;

endmodule

FILE: design/tcgr_checker.sv
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a result without a glyph row stands alone and carries no pixels
    `TCGR_ASSERT_NOW(a_nop_result, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 32'd0), "non-glyph result not last or not zero")

    // scroll only on the first result of a character
    `TCGR_ASSERT_NEXT(a_scroll_first, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !(m_tvalid && m_tuser[1]), "scroll flag after first result")

    // reset empties the result queue
    `TCGR_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // a stalled result stays offered
    `TCGR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
